// File: sv/hts_pkg.sv
// hts_pkg: shared constants for the horspool text search block
// no dependencies; imported by horspool_text_search, hts_props, hts_checker and tb_top
`default_nettype none
package hts_pkg;

	localparam int unsigned PATTERN_MAX_DEF = 16;
	localparam int unsigned TEXT_MAX_DEF    = 65536;

	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned WORD_W    = 64;
	localparam int unsigned LEN_REG_W = 5;
	localparam int unsigned START_W   = 16;
	localparam int unsigned CFG_IDX_W = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PAT_LOW  = 2'd0,
		REG_PAT_HIGH = 2'd1,
		REG_PAT_LEN  = 2'd2
	} cfg_reg_t;

endpackage : hts_pkg
`default_nettype wire

// File: sv/horspool_text_search.sv
// horspool_text_search: streamed boyer-moore-horspool search, one text byte per item
// a byte with no alignment check goes straight to the finish state; at an alignment check it
// compares window against pattern from the pattern's last byte, then on a mismatch (or with
// too few bytes seen) looks up the skip, then finishes, all through a single shared byte
// comparator; the result is registered as the finish state is left. Not ready while working
// or while a finished result waits on out_stall; reset: arst_n resets all state and registers at once
`default_nettype none
module horspool_text_search
	import hts_pkg::*;
#(
	parameter int unsigned PATTERN_MAX = PATTERN_MAX_DEF,
	parameter int unsigned TEXT_MAX    = TEXT_MAX_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [BYTE_W-1:0]    text_byte,
	input  wire logic                 last_byte,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic                      found,
	output logic [START_W-1:0]        match_start,
	input  wire logic                 cfg_write,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [WORD_W-1:0]    cfg_data
);

	localparam int unsigned IDXW  = $clog2(PATTERN_MAX);
	localparam int unsigned LENW  = $clog2(PATTERN_MAX + 1);
	localparam int unsigned SEENW = $clog2(TEXT_MAX) + 1;
	localparam logic [SEENW-1:0] SEEN_MAX = SEENW'(TEXT_MAX);
	localparam logic [LEN_REG_W-1:0] LEN_CAP = LEN_REG_W'(PATTERN_MAX);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMP,
		ST_SKIP,
		ST_FIN
	} state_t;

	state_t                 state_q;
	logic [WORD_W-1:0]      pat_low_q;
	logic [WORD_W-1:0]      pat_high_q;
	logic [LEN_REG_W-1:0]   pat_len_q;
	logic [BYTE_W-1:0]      win_q [PATTERN_MAX];
	logic [SEENW-1:0]       seen_q;
	logic [SEENW-1:0]       nca_q;
	logic                   done_q;
	logic [BYTE_W-1:0]      b_q;
	logic                   last_q;
	logic [IDXW-1:0]        cnt_q;
	logic                   res_pend_q;
	logic                   res_found_q;
	logic [START_W-1:0]     res_start_q;
	logic                   out_valid_q;
	logic                   found_q;
	logic [START_W-1:0]     match_start_q;

	logic [LEN_REG_W-1:0]   len_clip;
	logic [LENW-1:0]        len_eff;
	logic [IDXW-1:0]        lm1;
	logic                   len_small;
	logic [2*WORD_W-1:0]    pat_all;
	logic [IDXW-1:0]        pat_idx;
	logic [BYTE_W-1:0]      cmp_a;
	logic [BYTE_W-1:0]      cmp_b;
	logic                   cmp_eq;
	logic [SEENW-1:0]       seen_nxt;
	logic [SEENW-1:0]       nca_eff;
	logic [SEENW-1:0]       len_ext;
	logic                   emit;
	logic                   res_load;

	// effective pattern length, clipped to 1..PATTERN_MAX
	always_comb begin
		if (pat_len_q == '0) begin
			len_clip = LEN_REG_W'(1);
		end else if (pat_len_q > LEN_CAP) begin
			len_clip = LEN_CAP;
		end else begin
			len_clip = pat_len_q;
		end
	end

	assign len_eff   = LENW'(len_clip);
	assign lm1       = IDXW'(len_clip - LEN_REG_W'(1));
	assign len_small = (len_clip < LEN_REG_W'(2));
	assign len_ext   = SEENW'(len_eff);
	assign pat_all   = {pat_high_q, pat_low_q};

	// shared byte comparator
	assign pat_idx = (state_q == ST_CMP) ? IDXW'(lm1 - cnt_q) : cnt_q;
	assign cmp_a   = (state_q == ST_CMP) ? win_q[cnt_q] : b_q;
	assign cmp_b   = pat_all[pat_idx*BYTE_W +: BYTE_W];
	assign cmp_eq  = (cmp_a == cmp_b);

	assign seen_nxt = seen_q + SEENW'(1);
	assign nca_eff  = (seen_q == '0) ? len_ext : nca_q;
	assign emit     = res_pend_q || (last_q && !done_q);
	assign res_load = (state_q == ST_FIN) && emit && (!out_valid_q || !out_stall);

	assign in_stall    = (state_q != ST_IDLE);
	assign out_valid   = out_valid_q;
	assign found       = found_q;
	assign match_start = match_start_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_low_q  <= '0;
			pat_high_q <= '0;
			pat_len_q  <= LEN_REG_W'(1);
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_PAT_LOW:  pat_low_q  <= cfg_data;
				REG_PAT_HIGH: pat_high_q <= cfg_data;
				REG_PAT_LEN:  pat_len_q  <= cfg_data[LEN_REG_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			for (int j = 0; j < PATTERN_MAX; j++) begin
				win_q[j] <= '0;
			end
			seen_q        <= '0;
			nca_q         <= SEENW'(1);
			done_q        <= 1'b0;
			b_q           <= '0;
			last_q        <= 1'b0;
			cnt_q         <= '0;
			res_pend_q    <= 1'b0;
			res_found_q   <= 1'b0;
			res_start_q   <= '0;
			out_valid_q   <= 1'b0;
			found_q       <= 1'b0;
			match_start_q <= '0;
		end else begin
			if (out_valid_q && !out_stall && !res_load) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						b_q     <= text_byte;
						last_q  <= last_byte;
						state_q <= ST_FIN;
						if (!done_q) begin
							if (seen_q == SEEN_MAX) begin
								res_pend_q  <= 1'b1;
								res_found_q <= 1'b0;
								res_start_q <= '0;
								done_q      <= 1'b1;
							end else begin
								win_q[0] <= text_byte;
								for (int j = 1; j < PATTERN_MAX; j++) begin
									win_q[j] <= win_q[j-1];
								end
								seen_q <= seen_nxt;
								nca_q  <= nca_eff;
								if (seen_nxt == nca_eff) begin
									if (seen_nxt >= len_ext) begin
										cnt_q   <= '0;
										state_q <= ST_CMP;
									end else begin
										cnt_q   <= IDXW'(lm1 - IDXW'(1));
										state_q <= ST_SKIP;
									end
								end
							end
						end
					end
				end
				ST_CMP: begin
					if (!cmp_eq) begin
						cnt_q   <= IDXW'(lm1 - IDXW'(1));
						state_q <= ST_SKIP;
					end else if (cnt_q == lm1) begin
						res_pend_q  <= 1'b1;
						res_found_q <= 1'b1;
						res_start_q <= START_W'(seen_q - len_ext);
						done_q      <= 1'b1;
						state_q     <= ST_FIN;
					end else begin
						cnt_q <= cnt_q + IDXW'(1);
					end
				end
				ST_SKIP: begin
					// search pattern bytes 0..L-2 from the right for the window's newest byte
					if (len_small) begin
						nca_q   <= nca_q + len_ext;
						state_q <= ST_FIN;
					end else if (cmp_eq) begin
						nca_q   <= nca_q + SEENW'(IDXW'(lm1 - cnt_q));
						state_q <= ST_FIN;
					end else if (cnt_q == '0) begin
						nca_q   <= nca_q + len_ext;
						state_q <= ST_FIN;
					end else begin
						cnt_q <= cnt_q - IDXW'(1);
					end
				end
				ST_FIN: begin
					if (!emit || !out_valid_q || !out_stall) begin
						if (emit) begin
							out_valid_q   <= 1'b1;
							found_q       <= res_pend_q && res_found_q;
							match_start_q <= res_pend_q ? res_start_q : '0;
						end
						res_pend_q <= 1'b0;
						if (last_q) begin
							for (int j = 0; j < PATTERN_MAX; j++) begin
								win_q[j] <= '0;
							end
							seen_q <= '0;
							nca_q  <= len_ext;
							done_q <= 1'b0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule : horspool_text_search
`default_nettype wire

// File: sv/hts_checker.sv
// hts_props: port-level assertions for horspool_text_search, bound into horspool_text_search
// depends on hts_pkg and horspool_text_search
`default_nettype none
module hts_props
	import hts_pkg::*;
(
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 in_valid,
	input wire logic                 in_stall,
	input wire logic [BYTE_W-1:0]    text_byte,
	input wire logic                 last_byte,
	input wire logic                 out_valid,
	input wire logic                 out_stall,
	input wire logic                 found,
	input wire logic [START_W-1:0]   match_start,
	input wire logic                 cfg_write,
	input wire logic [CFG_IDX_W-1:0] cfg_index,
	input wire logic [WORD_W-1:0]    cfg_data
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(found) && $stable(match_start))
		else $error("stalled result changed");

	// not found carries a zero start index
	a_nf_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> match_start == '0)
		else $error("not found with nonzero start");

	// every accepted item keeps the block busy in the cycle after it is accepted
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("ready right after accepting an item");

	// a new result only appears out of item processing
	a_res_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared while idle");

endmodule : hts_props

bind horspool_text_search hts_props u_hts_props (.*);
`default_nettype wire

// File: test/hts_checker.sv
// hts_checker: watches the item channels and register port of horspool_text_search,
// tracks search state, predicts each result and compares it with the block's output
// depends on hts_pkg for widths, limits and register codes
module hts_checker
	import hts_pkg::*;
#(
	parameter int unsigned TEXT_MAX = TEXT_MAX_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  logic [BYTE_W-1:0]    text_byte,
	input  logic                 last_byte,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  logic                 found,
	input  logic [START_W-1:0]   match_start,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [WORD_W-1:0]    cfg_data,
	output int                   mismatches,
	output int                   outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic               hit;
		logic [START_W-1:0] start;
	} search_result_t;

	search_result_t awaited_results[$];

	logic [WORD_W-1:0]    pat_low;
	logic [WORD_W-1:0]    pat_high;
	logic [LEN_REG_W-1:0] len_code;
	logic [BYTE_W-1:0]    recent [PATTERN_MAX_DEF];
	int unsigned          seen_count;
	int unsigned          align_end;
	bit                   text_closed;

	initial begin
		mismatches = 0;
		outstanding = 0;
	end

	function automatic int unsigned active_length();
		int unsigned l;
		l = len_code;
		if (l < 1) l = 1;
		if (l > PATTERN_MAX_DEF) l = PATTERN_MAX_DEF;
		return l;
	endfunction

	function automatic logic [BYTE_W-1:0] pattern_byte(input int unsigned i);
		if (i < 8) return pat_low[8*i +: 8];
		return pat_high[8*(i-8) +: 8];
	endfunction

	// bad-character shift: last occurrence among all but the final pattern byte
	function automatic int unsigned skip_for(input logic [BYTE_W-1:0] b);
		int unsigned l;
		int unsigned s;
		l = active_length();
		s = l;
		for (int unsigned i = 0; i + 1 < l; i++)
			if (pattern_byte(i) == b) s = l - 1 - i;
		return s;
	endfunction

	task automatic restart_search();
		foreach (recent[k]) recent[k] = '0;
		seen_count = 0;
		align_end = active_length();
		text_closed = 1'b0;
	endtask

	task automatic report(input string what);
		mismatches++;
		$display("[%0t] hts_checker: %s", $time, what);
	endtask

	task automatic scan_byte(input logic [BYTE_W-1:0] b, input logic lst);
		int unsigned l;
		bit hit;
		if (!text_closed) begin
			if (seen_count >= TEXT_MAX) begin
				awaited_results.push_back(search_result_t'{hit: 1'b0, start: '0});
				text_closed = 1'b1;
			end else begin
				l = active_length();
				if (seen_count == 0) align_end = l;
				for (int k = PATTERN_MAX_DEF - 1; k > 0; k--) recent[k] = recent[k-1];
				recent[0] = b;
				seen_count++;
				if (seen_count == align_end) begin
					hit = (seen_count >= l);
					for (int unsigned k = 0; k < l; k++)
						if (recent[k] != pattern_byte(l - 1 - k)) hit = 1'b0;
					if (hit) begin
						awaited_results.push_back(search_result_t'{hit: 1'b1,
							start: START_W'(seen_count - l)});
						text_closed = 1'b1;
					end else begin
						align_end += skip_for(b);
					end
				end
			end
		end
		if (lst) begin
			if (!text_closed) awaited_results.push_back(search_result_t'{hit: 1'b0, start: '0});
			restart_search();
		end
	endtask

	task automatic check_result();
		search_result_t want;
		if (awaited_results.size() == 0) begin
			report($sformatf("result with none awaited: found=%b start=%0d", found, match_start));
			return;
		end
		want = awaited_results.pop_front();
		if (found !== want.hit || match_start !== want.start)
			report($sformatf("found=%b start=%0d, awaited found=%b start=%0d",
				found, match_start, want.hit, want.start));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_low = '0;
			pat_high = '0;
			len_code = LEN_REG_W'(1);
			restart_search();
			awaited_results.delete();
		end else begin
			if (out_valid && !out_stall) check_result();
			if (cfg_write) begin
				case (cfg_index)
					REG_PAT_LOW:  pat_low = cfg_data;
					REG_PAT_HIGH: pat_high = cfg_data;
					REG_PAT_LEN:  len_code = cfg_data[LEN_REG_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) scan_byte(text_byte, last_byte);
		end
		outstanding <= awaited_results.size();
	end

endmodule : hts_checker

// File: test/tb_top.sv
// tb_top: drives text items and pattern registers into horspool_text_search with bursty
// input, stalling output and one long text that reaches the text limit; gives the verdict
// depends on hts_pkg, horspool_text_search and hts_checker
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import hts_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;
	localparam int SETTLE_CYCLES = 2 * PATTERN_MAX_DEF + 8;
	localparam int RANDOM_ITEMS  = 1000;
	localparam int unsigned TEXT_LIMIT = 256;
	localparam int LONG_TEXT     = TEXT_LIMIT + 2;
	localparam int HOLD_CYCLES   = 400;

	typedef enum int {STALL_NONE, STALL_RANDOM, STALL_RUNS} stall_style_t;

	logic                 clk;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [BYTE_W-1:0]    text_byte = '0;
	logic                 last_byte = 1'b0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic                 found;
	logic [START_W-1:0]   match_start;
	logic                 cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [WORD_W-1:0]    cfg_data = '0;
	int                   mismatches;
	int                   outstanding;

	stall_style_t      stall_style = STALL_NONE;
	int                hold_asks = 0;
	bit                bursty = 1'b0;
	int                burst_left = 0;
	int                items_sent = 0;
	logic [BYTE_W-1:0] pat_now [PATTERN_MAX_DEF];
	int                pat_len = 1;
	logic [BYTE_W-1:0] text_buf [64];

	horspool_text_search #(
		.TEXT_MAX (TEXT_LIMIT)
	) uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.text_byte   (text_byte),
		.last_byte   (last_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.found       (found),
		.match_start (match_start),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	hts_checker #(
		.TEXT_MAX (TEXT_LIMIT)
	) u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.text_byte   (text_byte),
		.last_byte   (last_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.found       (found),
		.match_start (match_start),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("tb_top NOT OK");
		$finish;
	end

	initial begin : receiver
		int hold_done;
		int hold_left;
		int run_left;
		bit run_on;
		hold_done = 0;
		hold_left = 0;
		run_left = 0;
		run_on = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_done != hold_asks) begin
				hold_done = hold_asks;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				case (stall_style)
					STALL_NONE:   out_stall <= 1'b0;
					STALL_RANDOM: out_stall <= ($urandom_range(0, 2) == 0);
					default: begin
						if (run_left == 0) begin
							run_on = !run_on;
							run_left = run_on ? $urandom_range(1, 12) : $urandom_range(1, 6);
						end
						run_left--;
						out_stall <= run_on;
					end
				endcase
			end
		end
	end

	task automatic send_item(input logic [BYTE_W-1:0] b, input logic lst);
		if (bursty) begin
			if (burst_left == 0) begin
				@(negedge clk);
				in_valid <= 1'b0;
				repeat ($urandom_range(0, 5)) @(negedge clk);
				burst_left = $urandom_range(1, 16);
			end
			burst_left--;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		text_byte <= b;
		last_byte <= lst;
		do @(posedge clk); while (in_stall);
		items_sent++;
	endtask

	task automatic send_text(input int n, input bit closed);
		for (int i = 0; i < n; i++) send_item(text_buf[i], closed && i == n - 1);
	endtask

	task automatic send_literal(input logic [63:0] seq, input int n);
		for (int i = 0; i < n; i++) text_buf[i] = seq[8*(n-1-i) +: 8];
		send_text(n, 1'b1);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] value);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	// block idle: nothing awaited and any result-free item finished
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		burst_left = 0;
		while (outstanding != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic load_pattern(input logic [LEN_REG_W-1:0] code);
		logic [WORD_W-1:0] lo;
		logic [WORD_W-1:0] hi;
		logic [WORD_W-1:0] len_word;
		cfg_reg_t order [3];
		cfg_reg_t tmp;
		int j;
		for (int i = 0; i < 8; i++) begin
			lo[8*i +: 8] = pat_now[i];
			hi[8*i +: 8] = pat_now[i+8];
		end
		len_word = ($urandom_range(0, 1) == 0) ? '0 : {$urandom, $urandom};
		len_word[LEN_REG_W-1:0] = code;
		order[0] = REG_PAT_LOW;
		order[1] = REG_PAT_HIGH;
		order[2] = REG_PAT_LEN;
		for (int i = 0; i < 2; i++) begin
			j = $urandom_range(i, 2);
			tmp = order[i];
			order[i] = order[j];
			order[j] = tmp;
		end
		settle();
		for (int n = 0; n < 3; n++) begin
			case (order[n])
				REG_PAT_LOW:  write_reg(REG_PAT_LOW, lo);
				REG_PAT_HIGH: write_reg(REG_PAT_HIGH, hi);
				default:      write_reg(REG_PAT_LEN, len_word);
			endcase
		end
		if ($urandom_range(0, 3) == 0) write_reg(REG_UNMAPPED, {$urandom, $urandom});
		pat_len = (code == 0) ? 1 : (code > PATTERN_MAX_DEF) ? PATTERN_MAX_DEF : int'(code);
	endtask

	initial begin : stimulus
		int phase;
		int first_random;
		int n_texts;
		int tlen;
		int pos;
		int shape;
		int drain;
		logic [LEN_REG_W-1:0] code;
		logic [BYTE_W-1:0] base;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset pattern is a single zero byte
		foreach (pat_now[i]) pat_now[i] = '0;
		send_literal(64'h00, 1);
		send_literal(64'hff, 1);

		pat_now[0] = 8'h61;
		pat_now[1] = 8'h62;
		pat_now[2] = 8'h63;
		pat_now[3] = 8'h61;
		load_pattern(LEN_REG_W'(4));
		// text shorter than pattern, then a match followed by an ignored byte
		send_literal(64'h616263, 3);
		send_literal(64'h786162636100, 6);

		// zero length acts as one
		pat_now[0] = 8'h62;
		load_pattern(LEN_REG_W'(0));
		send_literal(64'h6162, 2);

		// length beyond the maximum acts as the maximum
		foreach (pat_now[i]) pat_now[i] = 8'($urandom_range(0, 255));
		load_pattern(LEN_REG_W'(31));
		foreach (pat_now[i]) text_buf[i] = pat_now[i];
		send_text(PATTERN_MAX_DEF, 1'b1);

		phase = 0;
		first_random = items_sent;
		while (items_sent - first_random < RANDOM_ITEMS) begin
			shape = $urandom_range(0, 9);
			base = 8'($urandom_range(0, 255));
			foreach (pat_now[i]) begin
				if (shape == 0) pat_now[i] = 8'h00;
				else if (shape == 1) pat_now[i] = 8'hff;
				else if (shape < 6) pat_now[i] = base + 8'($urandom_range(0, 2));
				else pat_now[i] = 8'($urandom_range(0, 255));
			end
			if (phase == 0) code = LEN_REG_W'(PATTERN_MAX_DEF);
			else if (phase == 1) code = LEN_REG_W'(1);
			else begin
				case ($urandom_range(0, 9))
					0: code = LEN_REG_W'(0);
					1: code = LEN_REG_W'(1);
					2: code = LEN_REG_W'(PATTERN_MAX_DEF);
					3: code = LEN_REG_W'($urandom_range(17, 31));
					default: code = LEN_REG_W'($urandom_range(2, 15));
				endcase
			end
			load_pattern(code);
			stall_style = stall_style_t'($urandom_range(0, 2));
			bursty = ($urandom_range(0, 3) != 0);
			if (phase % 4 == 1) hold_asks++;
			n_texts = $urandom_range(3, 10);
			for (int t = 0; t < n_texts; t++) begin
				tlen = ($urandom_range(0, 5) == 0) ? $urandom_range(1, pat_len)
					: $urandom_range(1, 48);
				for (int i = 0; i < tlen; i++) begin
					if (shape >= 2 && shape < 6)
						text_buf[i] = base + 8'($urandom_range(0, 3));
					else if ($urandom_range(0, 1) == 0)
						text_buf[i] = pat_now[$urandom_range(0, pat_len - 1)];
					else
						text_buf[i] = 8'($urandom_range(0, 255));
				end
				if (tlen >= pat_len && $urandom_range(0, 9) < 6) begin
					pos = $urandom_range(0, tlen - pat_len);
					for (int k = 0; k < pat_len; k++) text_buf[pos+k] = pat_now[k];
					if ($urandom_range(0, 4) == 0)
						text_buf[pos + $urandom_range(0, pat_len - 1)] = 8'($urandom_range(0, 255));
				end
				// an open text at phase end gets its registers rewritten mid-text
				send_text(tlen, !(t == n_texts - 1 && $urandom_range(0, 4) == 0));
			end
			phase++;
		end

		// one text past the limit, pattern never present
		foreach (pat_now[i]) pat_now[i] = 8'hff;
		load_pattern(LEN_REG_W'(PATTERN_MAX_DEF));
		stall_style = STALL_NONE;
		bursty = 1'b0;
		for (int i = 1; i <= LONG_TEXT; i++)
			send_item(8'($urandom_range(0, 254)), i == LONG_TEXT);
		foreach (pat_now[i]) text_buf[i] = pat_now[i];
		send_text(PATTERN_MAX_DEF, 1'b1);

		@(negedge clk);
		in_valid <= 1'b0;
		drain = 0;
		while (outstanding != 0 && drain < 20000) begin
			@(posedge clk);
			drain++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule : tb_top
